// File: rtl/fem_pkg.sv
// shared constants, types and helpers for the filename extension matcher
`timescale 1ns / 1ps
`default_nettype none

package fem_pkg;

   localparam int unsigned MAX_EXT_LEN_DEFAULT = 8;
   localparam int unsigned LEN_W  = 4;
   localparam int unsigned EXT_W  = 64;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned ADDR_W = 5;
   localparam int unsigned IDX_W  = 16;

   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_DOT   = 8'h2e;

   localparam logic [1:0] REG_EXT_BYTES  = 2'd0;
   localparam logic [1:0] REG_EXT_LENGTH = 2'd1;
   localparam logic [1:0] REG_FULL_MODE  = 2'd2;

   typedef struct packed {
      logic len_ok;
      logic full_ok;
   } fem_track_type;

   typedef struct packed {
      logic             selected;
      logic [IDX_W-1:0] string_index;
   } fem_rsp_type;

   function automatic logic [7:0] ext_char(input logic [EXT_W-1:0] bytes,
                                           input logic [2:0] idx);
      ext_char = bytes[{idx, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

// File: rtl/fem_cell.sv
// one byte cell of the tail window: holds a byte and checks the byte shifting in
`timescale 1ns / 1ps
`default_nettype none

module fem_cell #(
   parameter int unsigned POS = 0
) (
   input  wire logic                      clock,
   input  wire logic                      shift_en,
   input  wire logic [7:0]                byte_in,
   input  wire logic [fem_pkg::EXT_W-1:0] ext_bytes,
   input  wire logic [fem_pkg::LEN_W-1:0] ext_length,
   output logic [7:0]                     byte_out,
   output logic                           hit
);

   localparam logic [fem_pkg::LEN_W-1:0] POS_L = fem_pkg::LEN_W'(POS);

   logic [7:0]                byte_ff;
   logic [7:0]                byte_in_nxt;
   logic [fem_pkg::LEN_W-1:0] char_pos;

   assign char_pos    = ext_length - POS_L - fem_pkg::LEN_W'(1);
   assign byte_in_nxt = shift_en ? byte_in : byte_ff;

   always_comb begin
      if (POS_L < ext_length) begin
         hit = (byte_in == fem_pkg::ext_char(ext_bytes, char_pos[2:0]));
      end else if (POS_L == ext_length) begin
         hit = (byte_in == fem_pkg::CH_DOT);
      end else begin
         hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_nxt;
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

// File: rtl/fem_tracker.sv
// per-string length and basename extension tracking
`timescale 1ns / 1ps
`default_nettype none

module fem_tracker #(
   parameter int unsigned MAX_EXT_LEN = fem_pkg::MAX_EXT_LEN_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      take,
   input  wire logic                      finish,
   input  wire logic [7:0]                ch,
   input  wire logic [fem_pkg::EXT_W-1:0] ext_bytes,
   input  wire logic [fem_pkg::LEN_W-1:0] ext_length,
   output fem_pkg::fem_track_type         track
);

   localparam logic [fem_pkg::LEN_W-1:0] MAX_L = fem_pkg::LEN_W'(MAX_EXT_LEN);
   localparam logic [fem_pkg::LEN_W-1:0] SAT   = '1;

   logic [fem_pkg::LEN_W-1:0] length_seen_ff, length_seen_in, length_upd;
   logic                      in_extension_ff, in_extension_in, in_ext_upd;
   logic [fem_pkg::LEN_W-1:0] ext_count_ff, ext_count_in, count_upd;
   logic                      ext_mismatch_ff, ext_mismatch_in, mismatch_upd;

   always_comb begin
      length_upd   = (length_seen_ff == SAT) ? SAT : length_seen_ff + fem_pkg::LEN_W'(1);
      in_ext_upd   = in_extension_ff;
      count_upd    = ext_count_ff;
      mismatch_upd = ext_mismatch_ff;
      if (ch == fem_pkg::CH_SLASH) begin
         in_ext_upd   = 1'b0;
         count_upd    = '0;
         mismatch_upd = 1'b0;
      end else if (!in_extension_ff) begin
         if (ch == fem_pkg::CH_DOT) begin
            in_ext_upd   = 1'b1;
            count_upd    = '0;
            mismatch_upd = 1'b0;
         end
      end else begin
         if (ext_count_ff >= ext_length || ext_count_ff >= MAX_L ||
             ch != fem_pkg::ext_char(ext_bytes, ext_count_ff[2:0])) begin
            mismatch_upd = 1'b1;
         end
         if (ext_count_ff != SAT) begin
            count_upd = ext_count_ff + fem_pkg::LEN_W'(1);
         end
      end
   end

   // verdict looks at the state after the final byte
   assign track.len_ok  = (length_upd > ext_length);
   assign track.full_ok = in_ext_upd && !mismatch_upd && (count_upd == ext_length);

   always_comb begin
      length_seen_in  = length_seen_ff;
      in_extension_in = in_extension_ff;
      ext_count_in    = ext_count_ff;
      ext_mismatch_in = ext_mismatch_ff;
      if (finish) begin
         length_seen_in  = '0;
         in_extension_in = 1'b0;
         ext_count_in    = '0;
         ext_mismatch_in = 1'b0;
      end else if (take) begin
         length_seen_in  = length_upd;
         in_extension_in = in_ext_upd;
         ext_count_in    = count_upd;
         ext_mismatch_in = mismatch_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_seen_ff  <= '0;
         in_extension_ff <= 1'b0;
         ext_count_ff    <= '0;
         ext_mismatch_ff <= 1'b0;
      end else begin
         length_seen_ff  <= length_seen_in;
         in_extension_ff <= in_extension_in;
         ext_count_ff    <= ext_count_in;
         ext_mismatch_ff <= ext_mismatch_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/filename_extension_matcher.sv
// top level of the filename extension matcher
`timescale 1ns / 1ps
`default_nettype none

// Path strings come in one byte per transaction and each string gets one
// verdict on its last byte (or on a single transaction flagged empty), carrying
// its running string index. A byte is taken every cycle while req_ready is
// high: each byte shifts through a row of MAX_EXT_LEN+1 compare cells while a
// small tracker follows the basename extension, so the verdict is ready in the
// cycle its last byte arrives and is then registered. The result port has an
// output register plus one skid entry, so bytes keep flowing while one verdict
// waits; input stalls only when both are full. Registers sit at byte address
// 0 (ext_bytes), 8 (ext_length) and 16 (full_mode). The user must write them
// only while the block is idle; the block itself does not enforce this.
module filename_extension_matcher #(
   parameter int unsigned MAX_EXT_LEN = fem_pkg::MAX_EXT_LEN_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [7:0]                 req_ch,
   input  wire logic                       req_last_char,
   input  wire logic                       req_empty_string,
   input  wire logic                       req_eligible,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_selected,
   output logic [fem_pkg::IDX_W-1:0]       rsp_string_index,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [fem_pkg::ADDR_W-1:0] paddr,
   input  wire logic [fem_pkg::DATA_W-1:0] pwdata,
   output logic [fem_pkg::DATA_W-1:0]      prdata,
   output logic                            pready
);

   localparam logic [fem_pkg::LEN_W-1:0] MAX_L = fem_pkg::LEN_W'(MAX_EXT_LEN);

   // register file
   logic [fem_pkg::EXT_W-1:0] ext_bytes_ff;
   logic [fem_pkg::LEN_W-1:0] ext_length_ff;
   logic                      full_mode_ff;
   logic                      csr_write;
   logic [1:0]                csr_reg;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_reg   = paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_bytes_ff  <= '0;
         ext_length_ff <= '0;
         full_mode_ff  <= 1'b1;
      end else if (csr_write) begin
         case (csr_reg)
            fem_pkg::REG_EXT_BYTES:  ext_bytes_ff  <= pwdata;
            fem_pkg::REG_EXT_LENGTH: ext_length_ff <= pwdata[fem_pkg::LEN_W-1:0];
            fem_pkg::REG_FULL_MODE:  full_mode_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         fem_pkg::REG_EXT_BYTES:  prdata = ext_bytes_ff;
         fem_pkg::REG_EXT_LENGTH: prdata = fem_pkg::DATA_W'(ext_length_ff);
         fem_pkg::REG_FULL_MODE:  prdata = fem_pkg::DATA_W'(full_mode_ff);
         default:                 prdata = '0;
      endcase
   end

   // input side
   logic req_accept, take, finish;

   assign req_accept = req_valid && req_ready;
   assign take       = req_accept && !req_empty_string;
   assign finish     = req_accept && (req_last_char || req_empty_string);

   // tail window cells
   logic [7:0]           link [0:MAX_EXT_LEN];
   logic [MAX_EXT_LEN:0] hit;

   assign link[0] = req_ch;

   for (genvar k = 0; k <= MAX_EXT_LEN; k++) begin : g_cell
      if (k < MAX_EXT_LEN) begin : g_mid
         fem_cell #(.POS(k)) u_cell (
            .clock      (clock),
            .shift_en   (take),
            .byte_in    (link[k]),
            .ext_bytes  (ext_bytes_ff),
            .ext_length (ext_length_ff),
            .byte_out   (link[k+1]),
            .hit        (hit[k])
         );
      end else begin : g_end
         fem_cell #(.POS(k)) u_cell (
            .clock      (clock),
            .shift_en   (take),
            .byte_in    (link[k]),
            .ext_bytes  (ext_bytes_ff),
            .ext_length (ext_length_ff),
            .byte_out   (),
            .hit        (hit[k])
         );
      end
   end

   fem_pkg::fem_track_type track;

   fem_tracker #(.MAX_EXT_LEN(MAX_EXT_LEN)) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .finish     (finish),
      .ch         (req_ch),
      .ext_bytes  (ext_bytes_ff),
      .ext_length (ext_length_ff),
      .track      (track)
   );

   // verdict
   logic                          match;
   logic [fem_pkg::IDX_W-1:0]     string_counter_ff;
   fem_pkg::fem_rsp_type          rsp_new;

   assign match = (ext_length_ff <= MAX_L) && track.len_ok &&
                  (full_mode_ff ? track.full_ok : (&hit));

   assign rsp_new.selected     = !req_empty_string && req_eligible && match;
   assign rsp_new.string_index = string_counter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         string_counter_ff <= '0;
      end else if (finish) begin
         string_counter_ff <= string_counter_ff + fem_pkg::IDX_W'(1);
      end
   end

   // output register with skid entry
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   fem_pkg::fem_rsp_type out_ff, out_in;
   fem_pkg::fem_rsp_type skid_ff, skid_in;
   logic                 out_free;

   assign req_ready = !skid_valid_ff;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = finish;
            out_in       = rsp_new;
         end
      end else if (finish) begin
         skid_valid_in = 1'b1;
         skid_in       = rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_selected     = out_ff.selected;
   assign rsp_string_index = out_ff.string_index;

endmodule

`default_nettype wire

// File: rtl/fem_checker.sv
// port-level checks for the filename extension matcher and their binding
`timescale 1ns / 1ps
`default_nettype none

module fem_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_selected,
   input wire logic [fem_pkg::IDX_W-1:0]   rsp_string_index
);

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_selected) &&
                                  $stable(rsp_string_index))
      else $error("stalled result changed");

   // successive results carry successive string indexes
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid ||
         rsp_string_index == $past(rsp_string_index) + fem_pkg::IDX_W'(1))
      else $error("string index skipped or repeated");

   // input only stalls with a result pending on the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   // reset empties the result port
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind filename_extension_matcher fem_checker u_fem_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_selected     (rsp_selected),
   .rsp_string_index (rsp_string_index)
);

`default_nettype wire
